// File: sv/irpfe_pkg.sv
// ----------------------------------------------------------------------------
// irpfe_pkg
// Shared types and constants of the IR pulse frame encoder: register map,
// reset values, controller states and the controller/datapath command bus.
// ----------------------------------------------------------------------------
`default_nettype none

package irpfe_pkg;

  localparam int unsigned DurW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;
  localparam int unsigned PosW  = 3;
  localparam int unsigned BitW  = 3;
  localparam int unsigned CfgIdxW = 3;

  // Register map
  localparam logic [CfgIdxW-1:0] RegHdrMark  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHdrSpace = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBitMark  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOneSpace = 3'd3;
  localparam logic [CfgIdxW-1:0] RegZeroSpace = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMsgSpace = 3'd5;

  // Reset values in microseconds
  localparam logic [DurW-1:0] HdrMarkRst   = 16'd9000;
  localparam logic [DurW-1:0] HdrSpaceRst  = 16'd4000;
  localparam logic [DurW-1:0] BitMarkRst   = 16'd620;
  localparam logic [DurW-1:0] OneSpaceRst  = 16'd1600;
  localparam logic [DurW-1:0] ZeroSpaceRst = 16'd540;
  localparam logic [DurW-1:0] MsgSpaceRst  = 16'd19000;

  // Checksum seed and frame positions
  localparam logic [NibW-1:0] CheckInit = 4'hA;
  localparam logic [PosW-1:0] PosFirst  = 3'd0;
  localparam logic [PosW-1:0] PosMid    = 3'd3;
  localparam logic [PosW-1:0] PosLast   = 3'd6;
  localparam logic [PosW-1:0] PosBad    = 3'd7;
  localparam logic [BitW-1:0] BitLast   = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_TAIL0,
    ST_TAIL1,
    ST_TAIL2,
    ST_MSG,
    ST_CHK,
    ST_CLOSE
  } state_e;

  typedef enum logic [2:0] {
    SEL_HDR,
    SEL_DATA,
    SEL_CHK,
    SEL_ZERO,
    SEL_ONE,
    SEL_MSG,
    SEL_CLOSE
  } pair_sel_e;

  typedef struct packed {
    logic      accept;   // latch the input word
    logic      load;     // load a pair into the output register
    pair_sel_e sel;      // which pair to build
    logic      bit_adv;  // advance the bit counter
    logic      eor;      // last pair of this word
    logic      eof;      // closing pair of the frame
  } cmd_t;

  typedef struct packed {
    logic first;     // next word starts a frame
    logic item_mid;  // word in work is byte 3
    logic item_last; // word in work is byte 6
    logic bit_last;  // bit counter at bit 7
    logic out_free;  // output register can take a pair
  } status_t;

endpackage

`default_nettype wire

// File: sv/irpfe_ctrl.sv
// ----------------------------------------------------------------------------
// irpfe_ctrl
// Sequencer of the encoder: walks header, data bits, mid-frame tail,
// checksum bits and closing pair, one pair per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module irpfe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire irpfe_pkg::status_t status_i,
  output irpfe_pkg::cmd_t        cmd_o
);

  irpfe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irpfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      irpfe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.first ? irpfe_pkg::ST_HDR : irpfe_pkg::ST_DATA;
        end
      end
      irpfe_pkg::ST_HDR: begin
        if (status_i.out_free) state_d = irpfe_pkg::ST_DATA;
      end
      irpfe_pkg::ST_DATA: begin
        if (status_i.out_free && status_i.bit_last) begin
          if (status_i.item_mid) state_d = irpfe_pkg::ST_TAIL0;
          else if (status_i.item_last) state_d = irpfe_pkg::ST_CHK;
          else state_d = irpfe_pkg::ST_IDLE;
        end
      end
      irpfe_pkg::ST_TAIL0: begin
        if (status_i.out_free) state_d = irpfe_pkg::ST_TAIL1;
      end
      irpfe_pkg::ST_TAIL1: begin
        if (status_i.out_free) state_d = irpfe_pkg::ST_TAIL2;
      end
      irpfe_pkg::ST_TAIL2: begin
        if (status_i.out_free) state_d = irpfe_pkg::ST_MSG;
      end
      irpfe_pkg::ST_MSG: begin
        if (status_i.out_free) state_d = irpfe_pkg::ST_IDLE;
      end
      irpfe_pkg::ST_CHK: begin
        if (status_i.out_free && status_i.bit_last) state_d = irpfe_pkg::ST_CLOSE;
      end
      irpfe_pkg::ST_CLOSE: begin
        if (status_i.out_free) state_d = irpfe_pkg::ST_IDLE;
      end
      default: state_d = irpfe_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o.accept   = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.sel      = irpfe_pkg::SEL_HDR;
    cmd_o.bit_adv  = 1'b0;
    cmd_o.eor      = 1'b0;
    cmd_o.eof      = 1'b0;
    case (state_q)
      irpfe_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      irpfe_pkg::ST_HDR: begin
        cmd_o.load = status_i.out_free;
        cmd_o.sel  = irpfe_pkg::SEL_HDR;
      end
      irpfe_pkg::ST_DATA: begin
        cmd_o.load    = status_i.out_free;
        cmd_o.sel     = irpfe_pkg::SEL_DATA;
        cmd_o.bit_adv = status_i.out_free;
        cmd_o.eor     = status_i.bit_last && !status_i.item_mid && !status_i.item_last;
      end
      irpfe_pkg::ST_TAIL0: begin
        cmd_o.load = status_i.out_free;
        cmd_o.sel  = irpfe_pkg::SEL_ZERO;
      end
      irpfe_pkg::ST_TAIL1: begin
        cmd_o.load = status_i.out_free;
        cmd_o.sel  = irpfe_pkg::SEL_ONE;
      end
      irpfe_pkg::ST_TAIL2: begin
        cmd_o.load = status_i.out_free;
        cmd_o.sel  = irpfe_pkg::SEL_ZERO;
      end
      irpfe_pkg::ST_MSG: begin
        cmd_o.load = status_i.out_free;
        cmd_o.sel  = irpfe_pkg::SEL_MSG;
        cmd_o.eor  = 1'b1;
      end
      irpfe_pkg::ST_CHK: begin
        cmd_o.load    = status_i.out_free;
        cmd_o.sel     = irpfe_pkg::SEL_CHK;
        cmd_o.bit_adv = status_i.out_free;
      end
      irpfe_pkg::ST_CLOSE: begin
        cmd_o.load = status_i.out_free;
        cmd_o.sel  = irpfe_pkg::SEL_CLOSE;
        cmd_o.eor  = 1'b1;
        cmd_o.eof  = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // A word is taken only when nothing is in work.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> (state_q == irpfe_pkg::ST_IDLE) && !cmd_o.load)
    else $error("word accepted while a frame run is in work");

  // An accepted word always starts with the header or its data bits.
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == irpfe_pkg::ST_HDR) || (state_q == irpfe_pkg::ST_DATA))
    else $error("accepted word did not start a run");

  // End of frame only comes with the closing pair of the run.
  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eof |-> cmd_o.eor && (cmd_o.sel == irpfe_pkg::SEL_CLOSE))
    else $error("end of frame without end of run");

  // Leaving a run returns the sequencer to idle.
  a_eor_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && cmd_o.eor) |=> (state_q == irpfe_pkg::ST_IDLE))
    else $error("run ended but sequencer is not idle");

endmodule

`default_nettype wire

// File: sv/irpfe_dp.sv
// ----------------------------------------------------------------------------
// irpfe_dp
// Datapath of the encoder: timing registers, input word latch, frame
// position, checksum nibble, bit counter and the output pair register.
// ----------------------------------------------------------------------------
`default_nettype none

module irpfe_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [irpfe_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [irpfe_pkg::DurW-1:0]          cfg_data_i,
  input  wire logic [irpfe_pkg::ByteW-1:0]         payload_byte_i,
  input  wire logic [irpfe_pkg::DurW-1:0]          closing_gap_us_i,
  input  wire irpfe_pkg::cmd_t                     cmd_i,
  output irpfe_pkg::status_t                       status_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [irpfe_pkg::DurW-1:0]               mark_us_o,
  output logic [irpfe_pkg::DurW-1:0]               space_us_o,
  output logic                                     end_of_run_o,
  output logic                                     end_of_frame_o
);

  // Timing registers
  logic [irpfe_pkg::DurW-1:0] hdr_mark_q, hdr_space_q, bit_mark_q;
  logic [irpfe_pkg::DurW-1:0] one_space_q, zero_space_q, msg_space_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_mark_q   <= irpfe_pkg::HdrMarkRst;
      hdr_space_q  <= irpfe_pkg::HdrSpaceRst;
      bit_mark_q   <= irpfe_pkg::BitMarkRst;
      one_space_q  <= irpfe_pkg::OneSpaceRst;
      zero_space_q <= irpfe_pkg::ZeroSpaceRst;
      msg_space_q  <= irpfe_pkg::MsgSpaceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        irpfe_pkg::RegHdrMark:   hdr_mark_q   <= cfg_data_i;
        irpfe_pkg::RegHdrSpace:  hdr_space_q  <= cfg_data_i;
        irpfe_pkg::RegBitMark:   bit_mark_q   <= cfg_data_i;
        irpfe_pkg::RegOneSpace:  one_space_q  <= cfg_data_i;
        irpfe_pkg::RegZeroSpace: zero_space_q <= cfg_data_i;
        irpfe_pkg::RegMsgSpace:  msg_space_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame position and checksum
  logic [irpfe_pkg::PosW-1:0] pos_q, pos_d, pos_n;
  logic [irpfe_pkg::NibW-1:0] acc_q, acc_d, nib, sum;
  logic                       mid_q, last_q;
  logic [irpfe_pkg::NibW-1:0] chk_q;
  logic [irpfe_pkg::ByteW-1:0] byte_q;
  logic [irpfe_pkg::DurW-1:0] gap_q;
  logic [irpfe_pkg::BitW-1:0] bit_q;

  always_comb begin
    pos_n = (pos_q == irpfe_pkg::PosBad) ? irpfe_pkg::PosFirst : pos_q;
    nib   = (pos_n <= irpfe_pkg::PosMid) ? payload_byte_i[3:0] : payload_byte_i[7:4];
    sum   = acc_q + nib;
    if (pos_n == irpfe_pkg::PosLast) begin
      pos_d = irpfe_pkg::PosFirst;
      acc_d = irpfe_pkg::CheckInit;
    end else begin
      pos_d = pos_n + 3'd1;
      acc_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= irpfe_pkg::PosFirst;
      acc_q  <= irpfe_pkg::CheckInit;
      mid_q  <= 1'b0;
      last_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        pos_q  <= pos_d;
        acc_q  <= acc_d;
        mid_q  <= (pos_n == irpfe_pkg::PosMid);
        last_q <= (pos_n == irpfe_pkg::PosLast);
      end
      if (cmd_i.bit_adv) begin
        bit_q <= bit_q + 3'd1;
      end
    end
  end

  // Word latch; checksum nibble of the frame is held for the eighth byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= payload_byte_i;
      gap_q  <= closing_gap_us_i;
      chk_q  <= sum;
    end
  end

  // Pair selection
  logic [irpfe_pkg::ByteW-1:0] chk_byte;
  logic [irpfe_pkg::DurW-1:0]  mark_d, space_d;

  always_comb begin
    chk_byte = {chk_q, {irpfe_pkg::NibW{1'b0}}};
    mark_d   = bit_mark_q;
    space_d  = zero_space_q;
    case (cmd_i.sel)
      irpfe_pkg::SEL_HDR: begin
        mark_d  = hdr_mark_q;
        space_d = hdr_space_q;
      end
      irpfe_pkg::SEL_DATA:  space_d = byte_q[bit_q] ? one_space_q : zero_space_q;
      irpfe_pkg::SEL_CHK:   space_d = chk_byte[bit_q] ? one_space_q : zero_space_q;
      irpfe_pkg::SEL_ZERO:  space_d = zero_space_q;
      irpfe_pkg::SEL_ONE:   space_d = one_space_q;
      irpfe_pkg::SEL_MSG:   space_d = msg_space_q;
      irpfe_pkg::SEL_CLOSE: space_d = gap_q;
      default:              space_d = zero_space_q;
    endcase
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mark_us_o      <= mark_d;
      space_us_o     <= space_d;
      end_of_run_o   <= cmd_i.eor;
      end_of_frame_o <= cmd_i.eof;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.first     = (pos_n == irpfe_pkg::PosFirst);
  assign status_o.item_mid  = mid_q;
  assign status_o.item_last = last_q;
  assign status_o.bit_last  = (bit_q == irpfe_pkg::BitLast);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Never overwrite a pair the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.load)
    else $error("output pair overwritten while stalled");

  // The bit counter sits at bit 0 whenever a word is taken.
  a_bit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> (bit_q == '0))
    else $error("bit counter not aligned at word start");

  // A closing pair returns the frame to its start with a fresh checksum.
  a_frame_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && cmd_i.eof) |-> (pos_q == irpfe_pkg::PosFirst)
                                  && (acc_q == irpfe_pkg::CheckInit))
    else $error("frame state not restarted at closing pair");

endmodule

`default_nettype wire

// File: sv/ir_pulse_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_frame_encoder_top
// Pulse-distance IR frame encoder: turns seven payload bytes into
// mark/space duration pairs with header, mid-frame gap and checksum byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one payload byte per word,
//   bytes 0..6 of a frame in order; closing_gap_us_i matters only with byte 6.
//   Output channel (out_valid_o / out_stall_i) carries one mark/space pair per
//   word. end_of_run_o marks the last pair of an input word, end_of_frame_o
//   the closing pair of the whole frame.
//   Pairs per input word: byte 0 gives 9 (header + 8 bits), bytes 1, 2, 4, 5
//   give 8, byte 3 gives 12 (bits, fixed 0,1,0 and message gap), byte 6
//   gives 17 (bits, checksum byte, closing pair).
//   Flow: after a word is accepted, the sequencer loads its pairs one at a
//   time into the single output register, one pair per cycle while out_stall_i
//   does not hold a pair. A new word is taken only after the last pair of the
//   current word has loaded.
//   Stall: while out_stall_i holds a pair, the sequencer freezes and the
//   pair stays stable; the input is stalled until the last pair of the
//   current word sits in the output register.
//   Reset: timing registers return to 9000/4000/620/1600/540/19000 us, the
//   frame restarts at byte 0 with checksum seed 10. Write the timing
//   registers through cfg_we_i / cfg_idx_i / cfg_data_i only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_frame_encoder_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [irpfe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [irpfe_pkg::DurW-1:0]    cfg_data_i,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [irpfe_pkg::ByteW-1:0]   payload_byte_i,
  input  wire logic [irpfe_pkg::DurW-1:0]    closing_gap_us_i,
  // output words
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [irpfe_pkg::DurW-1:0]         mark_us_o,
  output logic [irpfe_pkg::DurW-1:0]         space_us_o,
  output logic                               end_of_run_o,
  output logic                               end_of_frame_o
);

  irpfe_pkg::cmd_t    cmd;
  irpfe_pkg::status_t status;

  // Sequencer: decides which pair goes out next
  irpfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: holds timing, word, checksum and the output pair
  irpfe_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .payload_byte_i   (payload_byte_i),
    .closing_gap_us_i (closing_gap_us_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mark_us_o        (mark_us_o),
    .space_us_o       (space_us_o),
    .end_of_run_o     (end_of_run_o),
    .end_of_frame_o   (end_of_frame_o)
  );

endmodule

`default_nettype wire

// File: dv/irpfe_pair_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irpfe_pair_checker
// Watches the configuration port and both channels of the IR pulse frame
// encoder. It keeps its own copy of the timing registers, the frame position
// and the checksum. From these it works out the mark/space pairs that each
// accepted payload word must produce, and it compares every accepted output
// word with the oldest pair still due.
// ----------------------------------------------------------------------------
module irpfe_pair_checker
  import irpfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DurW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [ByteW-1:0]    payload_byte_i,
  input  logic [DurW-1:0]     closing_gap_us_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [DurW-1:0]     mark_us_i,
  input  logic [DurW-1:0]     space_us_i,
  input  logic                end_of_run_i,
  input  logic                end_of_frame_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  typedef struct packed {
    logic [DurW-1:0] mark;
    logic [DurW-1:0] space;
    logic            eor;
    logic            eof;
  } pulse_pair_t;

  pulse_pair_t       pairs_due [$];
  logic [DurW-1:0]   timing [0:RegMsgSpace];
  logic [PosW-1:0]   frame_pos;
  logic [NibW-1:0]   chk_sum;
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void push_pair(logic [DurW-1:0] mark, logic [DurW-1:0] space,
                                    logic eor, logic eof);
    pulse_pair_t p;
    p.mark  = mark;
    p.space = space;
    p.eor   = eor;
    p.eof   = eof;
    pairs_due.push_back(p);
  endfunction

  // One pair per bit, LSB first.
  function automatic void push_bits(logic [ByteW-1:0] b, logic ends_run);
    for (int i = 0; i < ByteW; i++) begin
      push_pair(timing[RegBitMark], b[i] ? timing[RegOneSpace] : timing[RegZeroSpace],
                ends_run && (i == ByteW - 1), 1'b0);
    end
  endfunction

  function automatic void encode_word(logic [ByteW-1:0] b, logic [DurW-1:0] gap);
    logic [PosW-1:0] pos;
    pos = (frame_pos == PosBad) ? PosFirst : frame_pos;
    if (pos == PosFirst) begin
      push_pair(timing[RegHdrMark], timing[RegHdrSpace], 1'b0, 1'b0);
    end
    push_bits(b, (pos != PosMid) && (pos != PosLast));
    if (pos <= PosMid) begin
      chk_sum = chk_sum + b[NibW-1:0];
    end else begin
      chk_sum = chk_sum + b[ByteW-1:NibW];
    end
    if (pos == PosMid) begin
      push_pair(timing[RegBitMark], timing[RegZeroSpace], 1'b0, 1'b0);
      push_pair(timing[RegBitMark], timing[RegOneSpace], 1'b0, 1'b0);
      push_pair(timing[RegBitMark], timing[RegZeroSpace], 1'b0, 1'b0);
      push_pair(timing[RegBitMark], timing[RegMsgSpace], 1'b1, 1'b0);
    end
    if (pos == PosLast) begin
      push_bits({chk_sum, {NibW{1'b0}}}, 1'b0);
      push_pair(timing[RegBitMark], gap, 1'b1, 1'b1);
      frame_pos = PosFirst;
      chk_sum   = CheckInit;
    end else begin
      frame_pos = pos + PosW'(1);
    end
  endfunction

  function automatic void check_field(string name, logic [DurW-1:0] want,
                                      logic [DurW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pulse_pair_t want;
    if (!rst_ni) begin
      timing[RegHdrMark]   = HdrMarkRst;
      timing[RegHdrSpace]  = HdrSpaceRst;
      timing[RegBitMark]   = BitMarkRst;
      timing[RegOneSpace]  = OneSpaceRst;
      timing[RegZeroSpace] = ZeroSpaceRst;
      timing[RegMsgSpace]  = MsgSpaceRst;
      frame_pos = PosFirst;
      chk_sum   = CheckInit;
      pairs_due.delete();
      pending_o <= 0;
    end else begin
      // Writes to indexes past the map are dropped.
      if (cfg_we_i && cfg_idx_i <= RegMsgSpace) begin
        timing[cfg_idx_i] = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (pairs_due.size() == 0) begin
          $error("unexpected pair: mark_us %0d space_us %0d", mark_us_i, space_us_i);
          mismatches++;
        end else begin
          want = pairs_due.pop_front();
          check_field("mark_us", want.mark, mark_us_i);
          check_field("space_us", want.space, space_us_i);
          check_field("end_of_run", want.eor, end_of_run_i);
          check_field("end_of_frame", want.eof, end_of_frame_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        encode_word(payload_byte_i, closing_gap_us_i);
      end
      pending_o <= pairs_due.size();
    end
  end

endmodule

// File: dv/ir_pulse_frame_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_frame_encoder_top_tb
// Regression bench for the IR pulse frame encoder. A few directed frames
// under the reset timing come first, then phases of random payload words,
// each phase under a fresh timing set (all zero, all ones, mixed). Both
// channels idle in random bursts; the last phase runs at full rate. The
// pair checker predicts and compares; this module drives and gives the
// verdict.
// ----------------------------------------------------------------------------
module ir_pulse_frame_encoder_top_tb;
  import irpfe_pkg::*;

  typedef enum int unsigned {TimingZero, TimingFull, TimingMixed} timing_style_e;

  localparam int unsigned NumPhases = 9;
  localparam int unsigned SettleCycles = 4;  // margin; block is idle once its last pair loads
  localparam int unsigned TailCycles = 20;

  // Directed frames: all zeros, all ones, then alternating, single-bit and other mixed bytes.
  localparam logic [ByteW-1:0] DirBytes [21] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hA5, 8'h5A, 8'h01, 8'h80, 8'h0F, 8'hF0, 8'h3C
  };
  localparam logic [DurW-1:0] DirClosing [3] = '{16'h0000, 16'hFFFF, 16'h2A55};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = RegHdrMark;
  logic [DurW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  payload_byte = '0;
  logic [DurW-1:0]   closing_gap = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DurW-1:0]   mark_us;
  logic [DurW-1:0]   space_us;
  logic              end_of_run;
  logic              end_of_frame;
  logic              quiet = 1'b0;   // no stalls on the receiver side
  int unsigned       gap_pct = 0;    // odds of a sender gap before a word
  int unsigned       stall_left = 0;
  int unsigned       open_left = 0;
  int unsigned       pending;
  int unsigned       fail_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ir_pulse_frame_encoder_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .payload_byte_i   (payload_byte),
    .closing_gap_us_i (closing_gap),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .mark_us_o        (mark_us),
    .space_us_o       (space_us),
    .end_of_run_o     (end_of_run),
    .end_of_frame_o   (end_of_frame)
  );

  irpfe_pair_checker pair_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .payload_byte_i   (payload_byte),
    .closing_gap_us_i (closing_gap),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .mark_us_i        (mark_us),
    .space_us_i       (space_us),
    .end_of_run_i     (end_of_run),
    .end_of_frame_i   (end_of_frame),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  // Receiver: stall in bursts of random length, separated by open stretches
  // that are sometimes short and sometimes long enough to run whole frames.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (open_left != 0) begin
        open_left--;
      end else begin
        stall_left = $urandom_range(1, 12);
        open_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(0, 10);
      end
    end
  end

  function automatic logic [DurW-1:0] pick_duration(timing_style_e style);
    int unsigned roll;
    roll = $urandom_range(0, 5);
    if (style == TimingZero || (style == TimingMixed && roll == 0)) begin
      return '0;
    end else if (style == TimingFull || roll == 1) begin
      return '1;
    end
    return DurW'($urandom);
  endfunction

  // Offer one payload word, maybe after a sender gap; hold it until taken.
  // Call right after a rising edge.
  task automatic send_word(input logic [ByteW-1:0] b, input logic [DurW-1:0] gap);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    payload_byte <= b;
    closing_gap  <= gap;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted pair has come out, then let
  // the block finish its last word before anything else happens.
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write every index, the unmapped ones too; those writes must be dropped.
  task automatic load_timing(input timing_style_e style);
    logic [CfgIdxW-1:0] idx;
    idx = RegHdrMark;
    do begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= (idx <= RegMsgSpace) ? pick_duration(style) : DurW'($urandom);
      @(posedge clk);
      idx++;
    end while (idx != RegHdrMark);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ByteW-1:0] b;
    logic [DurW-1:0]  gap;
    int unsigned      words;
    int unsigned      roll;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under reset timing; closing gap is noise except on byte 6.
    gap_pct = 20;
    foreach (DirBytes[i]) begin
      gap = (i % 7 == 6) ? DirClosing[i / 7] : DurW'($urandom);
      send_word(DirBytes[i], gap);
    end
    drain_words();

    // Random phases. Word counts need not be whole frames, so timing changes
    // can also land in the middle of a frame.
    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) begin
        quiet <= 1'b1;
        gap_pct = 0;
      end else begin
        roll = $urandom_range(0, 2);
        gap_pct = (roll == 0) ? 0 : (roll == 1) ? 15 : 50;
      end
      load_timing((p == 0) ? TimingZero : (p == 1) ? TimingFull : TimingMixed);
      words = $urandom_range(35, 55);
      repeat (words) begin
        roll = $urandom_range(0, 9);
        b = (roll == 0) ? '0 : (roll == 1) ? '1 : ByteW'($urandom);
        roll = $urandom_range(0, 9);
        gap = (roll == 0) ? '0 : (roll == 1) ? '1 : DurW'($urandom);
        send_word(b, gap);
        // Hold off now and then until the output side has caught up.
        if (p != NumPhases - 1 && $urandom_range(0, 59) == 0) begin
          drain_words();
        end
      end
      drain_words();
    end

    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("ir_pulse_frame_encoder_top regression: pass");
    end else begin
      $display("ir_pulse_frame_encoder_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("ir_pulse_frame_encoder_top regression: fail");
    $finish;
  end

endmodule

// File: ir_pulse_frame_encoder_top.f
sv/irpfe_pkg.sv
sv/irpfe_ctrl.sv
sv/irpfe_dp.sv
sv/ir_pulse_frame_encoder_top.sv
dv/irpfe_pair_checker.sv
dv/ir_pulse_frame_encoder_top_tb.sv
